### rtl/core/assert_macros.svh
// Assertion macros used by the port-level checker ddn_checker of the project.
// No dependencies; each macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/ddn_pkg.sv
// Package for the date and day number converter: constants, command codes and helpers.
// No dependencies; used by ddn_datapath and date_day_number_converter.
package ddn_pkg;

    localparam int NUM_STAGES = 6;

    localparam logic [15:0] QMARK_PAIR  = 16'h3F3F;
    localparam logic [10:0] CYCLE_DAYS  = 11'd1461;
    localparam logic [8:0]  YEAR_DAYS   = 9'd365;
    localparam logic [15:0] CYCLE_RECIP = 16'd45933;
    localparam int          RECIP_SHIFT = 26;
    localparam logic [6:0]  SPLIT_YY    = 7'd70;
    localparam logic [7:0]  BASE_YY     = 8'd73;

    typedef enum logic {
        CMD_TO_NUMBER = 1'b0,
        CMD_TO_TEXT   = 1'b1
    } cmd_t;

    typedef struct packed {
        logic       ok;
        logic [6:0] value;
    } pair_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic pair_t parse_pair(input logic [15:0] t);
        pair_t p;
        p.ok    = 1'b0;
        p.value = '0;
        if (is_digit(t[7:0])) begin
            if (is_digit(t[15:8])) begin
                p.ok    = 1'b1;
                p.value = {3'b000, t[11:8]} * 7'd10 + {3'b000, t[3:0]};
            end
            else if (t[15:8] == 8'h20) begin
                p.ok    = 1'b1;
                p.value = {3'b000, t[3:0]};
            end
        end
        return p;
    endfunction

    function automatic logic [8:0] cum_days(input logic leap, input logic [3:0] idx);
        logic [8:0] days;
        case (idx)
            4'd0:    days = 9'd0;
            4'd1:    days = 9'd31;
            4'd2:    days = 9'd59;
            4'd3:    days = 9'd90;
            4'd4:    days = 9'd120;
            4'd5:    days = 9'd151;
            4'd6:    days = 9'd181;
            4'd7:    days = 9'd212;
            4'd8:    days = 9'd243;
            4'd9:    days = 9'd273;
            4'd10:   days = 9'd304;
            4'd11:   days = 9'd334;
            default: days = 9'd0;
        endcase
        if (leap && (idx >= 4'd2) && (idx <= 4'd11)) begin
            days = days + 9'd1;
        end
        return days;
    endfunction

    function automatic logic [15:0] make_pair(input logic [6:0] v);
        logic [14:0] scaled;
        logic [3:0]  tens;
        logic [6:0]  ones;
        scaled = {8'b0, v} * 15'd205;
        tens   = scaled[14:11];
        ones   = v - {3'b000, tens} * 7'd10;
        return {4'h3, tens, 4'h3, ones[3:0]};
    endfunction

endpackage

### rtl/core/date_day_number_converter.sv
// An accepted item moves through the stage registers s1_reg to s6_reg and then shows on the output registers.
// Throughput: one item per cycle; a stall holds each stage, and empty stages still fill.
// The day number split uses a reciprocal multiply in stage one and a correction in stage three.
// Reset clears the valid bit of every stage; the data registers are not reset.
// Depends on ddn_pkg and ddn_datapath.
module date_day_number_converter (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               cmd,
    input  logic [15:0]        day_text,
    input  logic [15:0]        month_text,
    input  logic [15:0]        year_text,
    input  logic signed [16:0] day_number_in,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [16:0] day_number_out,
    output logic [15:0]        day_text_out,
    output logic [15:0]        month_text_out,
    output logic [15:0]        year_text_out,
    output logic               status,
    output logic               assumed_1900s
);

    localparam int LAST = ddn_pkg::NUM_STAGES - 1;

    logic [LAST:0] valid_reg, valid_next;
    logic [LAST:0] stage_ready;
    logic [LAST:0] stage_en;

    always_comb
    begin
        stage_ready[LAST] = !valid_reg[LAST] || out_ready;
        for (int i = LAST - 1; i >= 0; i--) begin
            stage_ready[i] = !valid_reg[i] || stage_ready[i + 1];
        end
        stage_en[0]   = stage_ready[0] && in_valid;
        valid_next[0] = stage_ready[0] ? in_valid : valid_reg[0];
        for (int i = 1; i <= LAST; i++) begin
            stage_en[i]   = stage_ready[i] && valid_reg[i - 1];
            valid_next[i] = stage_ready[i] ? valid_reg[i - 1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[LAST];

    ddn_datapath u_datapath (
        .clk            (clk),
        .en             (stage_en),
        .cmd            (cmd),
        .day_text       (day_text),
        .month_text     (month_text),
        .year_text      (year_text),
        .day_number_in  (day_number_in),
        .day_number_out (day_number_out),
        .day_text_out   (day_text_out),
        .month_text_out (month_text_out),
        .year_text_out  (year_text_out),
        .status         (status),
        .assumed_1900s  (assumed_1900s)
    );

endmodule

### rtl/core/ddn_datapath.sv
// Six-stage datapath of the date and day number converter.
// Depends on ddn_pkg; stage enables come from the valid chain in the top level.
module ddn_datapath (
    input  logic                            clk,
    input  logic [ddn_pkg::NUM_STAGES-1:0]  en,
    input  logic                            cmd,
    input  logic [15:0]                     day_text,
    input  logic [15:0]                     month_text,
    input  logic [15:0]                     year_text,
    input  logic signed [16:0]              day_number_in,
    output logic signed [16:0]              day_number_out,
    output logic [15:0]                     day_text_out,
    output logic [15:0]                     month_text_out,
    output logic [15:0]                     year_text_out,
    output logic                            status,
    output logic                            assumed_1900s
);

    typedef struct packed {
        ddn_pkg::cmd_t cmd;
        logic          err;
        logic          neg;
        logic [6:0]    d;
        logic [3:0]    m;
        logic [6:0]    yy;
        logic [15:0]   raw;
        logic [5:0]    qe;
    } s1_t;

    typedef struct packed {
        ddn_pkg::cmd_t cmd;
        logic          err;
        logic          neg;
        logic          hi;
        logic [16:0]   base;
        logic [8:0]    part;
        logic [11:0]   r;
        logic [5:0]    q;
    } s2_t;

    typedef struct packed {
        ddn_pkg::cmd_t cmd;
        logic          err;
        logic          neg;
        logic          hi;
        logic [16:0]   val;
        logic [10:0]   r;
        logic [5:0]    q;
    } s3_t;

    typedef struct packed {
        ddn_pkg::cmd_t cmd;
        logic          err;
        logic          neg;
        logic          hi;
        logic [16:0]   val;
        logic          r0;
        logic          leap;
        logic [8:0]    dd;
        logic [7:0]    yv;
    } s4_t;

    typedef struct packed {
        ddn_pkg::cmd_t cmd;
        logic          err;
        logic          neg;
        logic          hi;
        logic [16:0]   val;
        logic [4:0]    dv;
        logic [3:0]    mo;
        logic [6:0]    ym;
    } s5_t;

    typedef struct packed {
        logic [16:0] num;
        logic [15:0] dt;
        logic [15:0] mt;
        logic [15:0] yt;
        logic        status;
        logic        assumed;
    } s6_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    s3_t s3_reg, s3_next;
    s4_t s4_reg, s4_next;
    s5_t s5_reg, s5_next;
    s6_t s6_reg, s6_next;

    ddn_pkg::pair_t pd, pm, py;
    logic [31:0]    prod;
    logic [6:0]     t;
    logic [15:0]    cyc_days;
    logic [10:0]    yr_days;
    logic [16:0]    rfull;
    logic [10:0]    rm;
    logic [1:0]     k;
    logic [10:0]    off;
    logic [10:0]    dd_full;
    logic [3:0]     mi;
    logic [8:0]     dv_full;

    always_comb
    begin
        pd   = ddn_pkg::parse_pair(day_text);
        pm   = ddn_pkg::parse_pair(month_text);
        py   = ddn_pkg::parse_pair(year_text);
        prod = day_number_in[15:0] * ddn_pkg::CYCLE_RECIP;

        s1_next.cmd = ddn_pkg::cmd_t'(cmd);
        s1_next.err = !pd.ok || !pm.ok || !py.ok || (pm.value == 7'd0) || (pm.value > 7'd12);
        s1_next.neg = day_number_in[16];
        s1_next.d   = pd.value;
        s1_next.m   = pm.value[3:0];
        s1_next.yy  = py.value;
        s1_next.raw = day_number_in[15:0];
        s1_next.qe  = prod[ddn_pkg::RECIP_SHIFT +: 6];
    end

    always_comb
    begin
        if (s1_reg.yy >= ddn_pkg::SPLIT_YY) begin
            t = s1_reg.yy - 7'd69;
        end
        else begin
            t = s1_reg.yy + 7'd31;
        end
        cyc_days = {11'b0, t[6:2]} * {5'b0, ddn_pkg::CYCLE_DAYS};
        yr_days  = {9'b0, t[1:0]} * {2'b0, ddn_pkg::YEAR_DAYS};
        rfull    = {1'b0, s1_reg.raw} - {11'b0, s1_reg.qe} * {6'b0, ddn_pkg::CYCLE_DAYS};

        s2_next.cmd  = s1_reg.cmd;
        s2_next.err  = s1_reg.err;
        s2_next.neg  = s1_reg.neg;
        s2_next.hi   = s1_reg.yy >= ddn_pkg::SPLIT_YY;
        s2_next.base = {1'b0, cyc_days} + {6'b0, yr_days} - {6'b0, ddn_pkg::CYCLE_DAYS};
        s2_next.part = ddn_pkg::cum_days(t[1:0] == 2'd3, s1_reg.m - 4'd1) + {2'b0, s1_reg.d};
        s2_next.r    = rfull[11:0];
        s2_next.q    = s1_reg.qe;
    end

    always_comb
    begin
        s3_next.cmd = s2_reg.cmd;
        s3_next.err = s2_reg.err;
        s3_next.neg = s2_reg.neg;
        s3_next.hi  = s2_reg.hi;
        s3_next.val = s2_reg.base + {8'b0, s2_reg.part};
        if (s2_reg.r >= {1'b0, ddn_pkg::CYCLE_DAYS}) begin
            s3_next.r = 11'(s2_reg.r - {1'b0, ddn_pkg::CYCLE_DAYS});
            s3_next.q = s2_reg.q + 6'd1;
        end
        else begin
            s3_next.r = s2_reg.r[10:0];
            s3_next.q = s2_reg.q;
        end
    end

    always_comb
    begin
        rm = s3_reg.r - 11'd1;
        if (rm >= 11'(3 * ddn_pkg::YEAR_DAYS)) begin
            k = 2'd3;
        end
        else if (rm >= 11'(2 * ddn_pkg::YEAR_DAYS)) begin
            k = 2'd2;
        end
        else if (rm >= {2'b0, ddn_pkg::YEAR_DAYS}) begin
            k = 2'd1;
        end
        else begin
            k = 2'd0;
        end
        off     = {9'b0, k} * {2'b0, ddn_pkg::YEAR_DAYS};
        dd_full = rm - off + 11'd1;

        s4_next.cmd = s3_reg.cmd;
        s4_next.err = s3_reg.err;
        s4_next.neg = s3_reg.neg;
        s4_next.hi  = s3_reg.hi;
        s4_next.val = s3_reg.val;
        s4_next.r0  = s3_reg.r == 11'd0;
        s4_next.dd  = dd_full[8:0];
        if (s3_reg.r == 11'd0) begin
            s4_next.yv = ddn_pkg::BASE_YY - 8'd1 + {s3_reg.q, 2'b00};
        end
        else begin
            s4_next.yv = ddn_pkg::BASE_YY + {s3_reg.q, 2'b00} + {6'b0, k};
        end
        s4_next.leap = s4_next.yv[1:0] == 2'd0;
    end

    always_comb
    begin
        mi = 4'd0;
        for (int j = 1; j < 12; j++) begin
            if (s4_reg.dd > ddn_pkg::cum_days(s4_reg.leap, 4'(j))) begin
                mi = mi + 4'd1;
            end
        end
        dv_full = s4_reg.dd - ddn_pkg::cum_days(s4_reg.leap, mi);

        s5_next.cmd = s4_reg.cmd;
        s5_next.err = s4_reg.err;
        s5_next.neg = s4_reg.neg;
        s5_next.hi  = s4_reg.hi;
        s5_next.val = s4_reg.val;
        if (s4_reg.r0) begin
            s5_next.dv = 5'd31;
            s5_next.mo = 4'd12;
        end
        else begin
            s5_next.dv = dv_full[4:0];
            s5_next.mo = mi + 4'd1;
        end
        if (s4_reg.yv >= 8'd200) begin
            s5_next.ym = 7'(s4_reg.yv - 8'd200);
        end
        else if (s4_reg.yv >= 8'd100) begin
            s5_next.ym = 7'(s4_reg.yv - 8'd100);
        end
        else begin
            s5_next.ym = s4_reg.yv[6:0];
        end
    end

    always_comb
    begin
        s6_next = '0;
        if (s5_reg.cmd == ddn_pkg::CMD_TO_NUMBER) begin
            s6_next.status = s5_reg.err;
            if (!s5_reg.err) begin
                s6_next.num     = s5_reg.val;
                s6_next.assumed = s5_reg.hi;
            end
        end
        else if (s5_reg.neg) begin
            s6_next.dt     = ddn_pkg::QMARK_PAIR;
            s6_next.mt     = ddn_pkg::QMARK_PAIR;
            s6_next.yt     = ddn_pkg::QMARK_PAIR;
            s6_next.status = 1'b1;
        end
        else begin
            s6_next.dt = ddn_pkg::make_pair({2'b0, s5_reg.dv});
            s6_next.mt = ddn_pkg::make_pair({3'b0, s5_reg.mo});
            s6_next.yt = ddn_pkg::make_pair(s5_reg.ym);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0]) begin
            s1_reg <= s1_next;
        end
        if (en[1]) begin
            s2_reg <= s2_next;
        end
        if (en[2]) begin
            s3_reg <= s3_next;
        end
        if (en[3]) begin
            s4_reg <= s4_next;
        end
        if (en[4]) begin
            s5_reg <= s5_next;
        end
        if (en[5]) begin
            s6_reg <= s6_next;
        end
    end

    assign day_number_out = s6_reg.num;
    assign day_text_out   = s6_reg.dt;
    assign month_text_out = s6_reg.mt;
    assign year_text_out  = s6_reg.yt;
    assign status         = s6_reg.status;
    assign assumed_1900s  = s6_reg.assumed;

endmodule

### rtl/core/ddn_checker.sv
// Port-level checker for date_day_number_converter, attached by the bind at the end.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module ddn_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               cmd,
    input logic [15:0]        day_text,
    input logic [15:0]        month_text,
    input logic [15:0]        year_text,
    input logic signed [16:0] day_number_in,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [16:0] day_number_out,
    input logic [15:0]        day_text_out,
    input logic [15:0]        month_text_out,
    input logic [15:0]        year_text_out,
    input logic               status,
    input logic               assumed_1900s
);

    `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(day_number_out) && $stable(day_text_out) && $stable(status), "Stalled output item changed.")

    `ASSERT_SAME(a_empty_ready, !out_valid, in_ready, "Input stalled while the output stage is empty.")

    `ASSERT_SAME(a_one_kind, out_valid, day_number_out == 17'd0 || day_text_out == 16'h0000, "Item carries both a day number and date text.")

    `ASSERT_SAME(a_err_zero, out_valid && status, day_number_out == 17'd0 && !assumed_1900s, "Error item carries a day number or the 1900s flag.")

    `ASSERT_SAME(a_neg_qmark, out_valid && status && day_text_out != 16'h0000, month_text_out == 16'h3F3F && year_text_out == 16'h3F3F, "Negative day number item lacks question-mark pairs.")

endmodule

bind date_day_number_converter ddn_checker u_ddn_checker (.*);

### bench/ddn_checker.sv
// Conversion checker for the date and day number converter: watches both channels,
// predicts each result from the accepted item and compares it field by field.
// Depends on ddn_pkg for the command codes and the question-mark pair.
`timescale 1ns / 100ps

module ddn_conversion_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic               cmd,
    input  logic [15:0]        day_text,
    input  logic [15:0]        month_text,
    input  logic [15:0]        year_text,
    input  logic signed [16:0] day_number_in,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [16:0] day_number_out,
    input  logic [15:0]        day_text_out,
    input  logic [15:0]        month_text_out,
    input  logic [15:0]        year_text_out,
    input  logic               status,
    input  logic               assumed_1900s,
    output int                 fail_count,
    output int                 pending,
    output int                 checked_count,
    output int                 invalid_count
);

    localparam logic      STATUS_OK      = 1'b0;
    localparam logic      STATUS_INVALID = 1'b1;
    localparam logic [7:0] CHAR_SPACE    = 8'h20;
    localparam logic [7:0] CHAR_ZERO     = 8'h30;
    localparam logic [7:0] CHAR_NINE     = 8'h39;
    localparam int        FIRST_YEAR     = 1973;
    localparam int        FOUR_YEAR_DAYS = 1461;
    localparam int        YEAR_LEN       = 365;

    typedef struct packed {
        logic signed [16:0] number;
        logic [15:0]        day_txt;
        logic [15:0]        month_txt;
        logic [15:0]        year_txt;
        logic               stat;
        logic               century_guess;
    } conv_result_t;

    conv_result_t expected_q[$];

    initial begin
        fail_count    = 0;
        pending       = 0;
        checked_count = 0;
        invalid_count = 0;
    end

    // Returns -1 for a malformed pair.
    function automatic int pair_value(logic [15:0] t);
        logic [7:0] hi;
        logic [7:0] lo;
        hi = t[15:8];
        lo = t[7:0];
        if (lo < CHAR_ZERO || lo > CHAR_NINE)
            return -1;
        if (hi >= CHAR_ZERO && hi <= CHAR_NINE)
            return (hi - CHAR_ZERO) * 10 + (lo - CHAR_ZERO);
        if (hi == CHAR_SPACE)
            return lo - CHAR_ZERO;
        return -1;
    endfunction

    function automatic logic [15:0] ascii_pair(int v);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = 8'(CHAR_ZERO + (v % 100) / 10);
        ones = 8'(CHAR_ZERO + v % 10);
        return {tens, ones};
    endfunction

    function automatic int days_before(int month_idx, bit leap);
        int days;
        case (month_idx)
            0:       days = 0;
            1:       days = 31;
            2:       days = 59;
            3:       days = 90;
            4:       days = 120;
            5:       days = 151;
            6:       days = 181;
            7:       days = 212;
            8:       days = 243;
            9:       days = 273;
            10:      days = 304;
            default: days = 334;
        endcase
        if (leap && month_idx >= 2)
            days = days + 1;
        return days;
    endfunction

    function automatic conv_result_t predict_conversion(logic c, logic [15:0] dt,
                                                        logic [15:0] mt, logic [15:0] yt,
                                                        logic signed [16:0] n);
        conv_result_t res;
        int d;
        int m;
        int yy;
        int y;
        int cyc;
        int val;
        int i;
        int q;
        int r;
        int dd;
        bit leap;
        res = '0;
        if (c == ddn_pkg::CMD_TO_NUMBER) begin
            d  = pair_value(dt);
            m  = pair_value(mt);
            yy = pair_value(yt);
            if (d < 0 || m < 1 || m > 12 || yy < 0) begin
                res.stat = STATUS_INVALID;
                return res;
            end
            if (yy < 70) begin
                y = 2000 + yy;
            end
            else begin
                y = 1900 + yy;
                res.century_guess = 1'b1;
            end
            cyc  = (y - FIRST_YEAR + 4) / 4 - 1;
            leap = (y % 4) == 0;
            if (leap)
                val = cyc * FOUR_YEAR_DAYS + 3 * YEAR_LEN + days_before(m - 1, 1'b1) + d;
            else
                val = cyc * FOUR_YEAR_DAYS + ((y - 1) % 4) * YEAR_LEN
                      + days_before(m - 1, 1'b0) + d;
            res.number = val[16:0];
            res.stat   = STATUS_OK;
            return res;
        end
        if (n < 0) begin
            res.day_txt   = ddn_pkg::QMARK_PAIR;
            res.month_txt = ddn_pkg::QMARK_PAIR;
            res.year_txt  = ddn_pkg::QMARK_PAIR;
            res.stat      = STATUS_INVALID;
            return res;
        end
        i = n;
        q = i / FOUR_YEAR_DAYS;
        r = i % FOUR_YEAR_DAYS;
        if (r == 0) begin
            y = FIRST_YEAR + 4 * q - 1;
            m = 12;
            d = 31;
        end
        else begin
            y    = FIRST_YEAR + 4 * q + (r - 1) / YEAR_LEN;
            dd   = (r - 1) % YEAR_LEN + 1;
            leap = (y % 4) == 0;
            m    = 11;
            while (m > 0 && dd <= days_before(m, leap))
                m--;
            d = dd - days_before(m, leap);
            m = m + 1;
        end
        res.day_txt   = ascii_pair(d);
        res.month_txt = ascii_pair(m);
        res.year_txt  = ascii_pair(y % 100);
        res.stat      = STATUS_OK;
        return res;
    endfunction

    task automatic check_field(string field, logic [16:0] want, logic [16:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    always @(posedge clk) begin : watch
        conv_result_t want;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (expected_q.size() == 0) begin
                    fail_count++;
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h %b %b",
                             $time, day_number_out, day_text_out, month_text_out,
                             year_text_out, status, assumed_1900s);
                end
                else begin
                    want = expected_q.pop_front();
                    check_field("day_number_out", want.number, day_number_out);
                    check_field("day_text_out", {1'b0, want.day_txt}, {1'b0, day_text_out});
                    check_field("month_text_out", {1'b0, want.month_txt},
                                {1'b0, month_text_out});
                    check_field("year_text_out", {1'b0, want.year_txt},
                                {1'b0, year_text_out});
                    check_field("status", {16'b0, want.stat}, {16'b0, status});
                    check_field("assumed_1900s", {16'b0, want.century_guess},
                                {16'b0, assumed_1900s});
                    checked_count++;
                    if (want.stat == STATUS_INVALID)
                        invalid_count++;
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_conversion(cmd, day_text, month_text,
                                                        year_text, day_number_in));
        end
        pending <= expected_q.size();
    end

endmodule

### bench/tb_top.sv
// Top of the converter testbench: clock, reset, directed and random items, output stalls
// and the verdict. Depends on ddn_pkg, date_day_number_converter and ddn_conversion_checker.
`timescale 1ns / 100ps

module tb_top;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam int         TAIL_CYCLES = 20;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic               cmd = ddn_pkg::CMD_TO_NUMBER;
    logic [15:0]        day_text = '0;
    logic [15:0]        month_text = '0;
    logic [15:0]        year_text = '0;
    logic signed [16:0] day_number_in = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [16:0] day_number_out;
    logic [15:0]        day_text_out;
    logic [15:0]        month_text_out;
    logic [15:0]        year_text_out;
    logic               status;
    logic               assumed_1900s;

    int fail_count;
    int pending;
    int checked_count;
    int invalid_count;
    int directed_count = 0;
    int random_count = 0;
    bit steady = 1'b0;

    date_day_number_converter DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .day_text       (day_text),
        .month_text     (month_text),
        .year_text      (year_text),
        .day_number_in  (day_number_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .day_number_out (day_number_out),
        .day_text_out   (day_text_out),
        .month_text_out (month_text_out),
        .year_text_out  (year_text_out),
        .status         (status),
        .assumed_1900s  (assumed_1900s)
    );

    ddn_conversion_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .cmd            (cmd),
        .day_text       (day_text),
        .month_text     (month_text),
        .year_text      (year_text),
        .day_number_in  (day_number_in),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .day_number_out (day_number_out),
        .day_text_out   (day_text_out),
        .month_text_out (month_text_out),
        .year_text_out  (year_text_out),
        .status         (status),
        .assumed_1900s  (assumed_1900s),
        .fail_count     (fail_count),
        .pending        (pending),
        .checked_count  (checked_count),
        .invalid_count  (invalid_count)
    );

    always #1 clk = ~clk;

    always @(posedge clk) begin
        out_ready <= steady || ($urandom_range(99) >= 9);
    end

    task automatic send_item(logic c, logic [15:0] dt, logic [15:0] mt, logic [15:0] yt,
                             logic signed [16:0] n);
        while (!steady && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid      <= 1'b1;
        cmd           <= c;
        day_text      <= dt;
        month_text    <= mt;
        year_text     <= yt;
        day_number_in <= n;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic [15:0] digit_pair(int v);
        logic [7:0] tens;
        logic [7:0] ones;
        tens = 8'(8'h30 + v / 10);
        ones = 8'(8'h30 + v % 10);
        if (v < 10 && $urandom_range(3) == 0)
            tens = CHAR_SPACE;
        return {tens, ones};
    endfunction

    // Mostly a clean pair; sometimes one byte or the whole pair is replaced by noise.
    function automatic logic [15:0] text_field(int v, int noise_pct);
        logic [15:0] t;
        t = digit_pair(v);
        if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(2))
                0:       t[15:8] = 8'($urandom_range(255));
                1:       t[7:0] = 8'($urandom_range(255));
                default: t = 16'($urandom);
            endcase
        end
        return t;
    endfunction

    initial begin : stimulus
        int sel;
        logic signed [16:0] n;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(ddn_pkg::CMD_TO_NUMBER, "01", "01", "73", 17'sd5);
        send_item(ddn_pkg::CMD_TO_NUMBER, "31", "12", "72", -17'sd1);
        send_item(ddn_pkg::CMD_TO_NUMBER, "01", "01", "70", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "29", "02", "00", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "99", "12", "99", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "00", "01", "69", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, " 5", " 3", " 4", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "15", "00", "80", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "15", "13", "80", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "1:", "06", "90", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "/5", "06", "90", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, "05", "06", "x9", 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd0);
        send_item(ddn_pkg::CMD_TO_NUMBER, 16'h0000, 16'h0000, 16'h0000, -17'sd65536);
        send_item(ddn_pkg::CMD_TO_TEXT, "12", "12", "12", 17'sd0);
        send_item(ddn_pkg::CMD_TO_TEXT, 16'hFFFF, 16'hFFFF, 16'hFFFF, 17'sd1);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", 17'sd1460);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", 17'sd1461);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", 17'sd1096);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", 17'sd1155);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", 17'sd65535);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", -17'sd1);
        send_item(ddn_pkg::CMD_TO_TEXT, "00", "00", "00", -17'sd65536);
        directed_count = 23;

        for (int k = 0; k < 800; k++) begin
            steady = (k >= 300) && (k < 450);
            if ($urandom_range(1) == 0) begin
                sel = $urandom_range(99);
                send_item(ddn_pkg::CMD_TO_NUMBER,
                          text_field(sel < 85 ? $urandom_range(31, 1) : $urandom_range(99), 5),
                          text_field(sel < 95 ? $urandom_range(12, 1) : $urandom_range(99), 5),
                          text_field($urandom_range(99), 5),
                          17'($urandom));
            end
            else begin
                sel = $urandom_range(99);
                if (sel < 65)
                    n = 17'($urandom_range(36600));
                else if (sel < 80)
                    n = 17'(1461 * $urandom_range(40) + 365 * $urandom_range(3)
                            + $urandom_range(2) - 1);
                else
                    n = 17'($urandom);
                send_item(ddn_pkg::CMD_TO_TEXT, 16'($urandom), 16'($urandom), 16'($urandom), n);
            end
            random_count++;
        end
        steady = 1'b0;
        in_valid <= 1'b0;
        @(posedge clk);

        while (pending != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d directed and %0d random conversions in both directions.",
                 directed_count, random_count);
        $display("Checked %0d results, %0d of them reporting invalid input.",
                 checked_count, invalid_count);
        if (fail_count == 0 && pending == 0)
            $display("PASS date_day_number_converter");
        else
            $display("FAIL date_day_number_converter");
        $finish;
    end

    initial begin : watchdog
        #400000;
        $display("FAIL date_day_number_converter");
        $finish;
    end

endmodule

### date_day_number_converter.f
+incdir+rtl/core
rtl/core/ddn_pkg.sv
rtl/core/ddn_datapath.sv
rtl/core/date_day_number_converter.sv
rtl/core/ddn_checker.sv
bench/ddn_checker.sv
bench/tb_top.sv
